FILE: src/tmtw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_pkg
// Shared types and constants of the text-mode terminal writer.
// ----------------------------------------------------------------------------
package tmtw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = ATTR_W + CHAR_W;
    localparam int OUT_POS_W = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEXT_ATTR  = 2'd0,
        REG_BLANK_ATTR = 2'd1
    } t_cfg_reg;

    // Command class decided by the front end
    typedef enum logic [1:0] {
        CMD_PRINT = 2'd0,
        CMD_CR    = 2'd1,
        CMD_LF    = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd              kind;
        logic [CHAR_W-1:0] code;
    } t_item;

    typedef struct packed {
        logic [ATTR_W-1:0] text;
        logic [ATTR_W-1:0] blank;
    } t_attr;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_SCROLL = 3'd2,
        ST_EXEC   = 3'd3,
        ST_LF     = 3'd4
    } t_back_state;

endpackage
`default_nettype wire

FILE: src/tmtw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_front
// Classifies incoming bytes and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module tmtw_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [tmtw_pkg::CHAR_W-1:0]  i_code,
    output logic                         o_q_valid,
    input  wire                          i_q_ready,
    output tmtw_pkg::t_item              o_q_item
);
    import tmtw_pkg::*;

    t_item      r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_wp, r_rp;
    logic       w_push, w_pop;
    t_item      w_item;

    always_comb begin
        w_item.code = i_code;
        if (i_code == CODE_CR) begin
            w_item.kind = CMD_CR;
        end else if (i_code == CODE_LF) begin
            w_item.kind = CMD_LF;
        end else begin
            w_item.kind = CMD_PRINT;
        end
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_pop) |=> (r_cnt == 2'd2))
        else $error("queue count moved while full and not popped");

endmodule
`default_nettype wire

FILE: src/tmtw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_back
// Executes queued commands: owns the screen store, the cursor and the
// result register.
// ----------------------------------------------------------------------------
module tmtw_back #(
    parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_q_valid,
    output logic                            o_q_ready,
    input  tmtw_pkg::t_item                 i_q_item,
    input  tmtw_pkg::t_attr                 i_attr,
    output logic                            o_clearing,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [tmtw_pkg::OUT_POS_W-1:0]  o_cursor_position,
    output logic                            o_scrolled
);
    import tmtw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int LIN_W      = $clog2(CELL_COUNT + 1);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);

    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [LIN_W-1:0]  BOTTOM_LIN = LIN_W'(CELL_COUNT - COLUMNS);
    localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, CODE_SPACE};

    logic [CELL_W-1:0] mem [CELL_COUNT];

    t_back_state       r_state, n_state;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [ROW_W-1:0]  r_row, n_row;     // logical cursor row
    logic [ROW_W-1:0]  r_prow, n_prow;   // physical row in the ring
    logic [ROW_W-1:0]  r_top, n_top;     // physical row shown on top
    logic [COL_W-1:0]  r_col, n_col;
    logic [COL_W-1:0]  r_wcol, n_wcol;   // blanking column
    logic [LIN_W-1:0]  r_lin, n_lin;
    logic              r_past, n_past;
    t_item             r_cmd, n_cmd;
    logic              r_scr, n_scr;
    logic              r_out_valid, n_out_valid;
    logic [LIN_W-1:0]  r_out_lin, n_out_lin;
    logic              r_out_scr, n_out_scr;

    logic              w_we;
    logic [ADDR_W-1:0] w_addr;
    logic [CELL_W-1:0] w_data;
    logic [ROW_W-1:0]  w_wrow;
    logic [COL_W-1:0]  w_wc;
    logic              w_out_free;
    logic [CELL_W-1:0] w_blank;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_blank    = {i_attr.blank, CODE_SPACE};
    assign w_addr     = (w_we && r_state == ST_CLEAR) ? r_clr
                      : ADDR_W'(w_wrow * COLUMNS) + ADDR_W'(w_wc);

    assign o_q_ready         = (r_state == ST_IDLE) && w_out_free;
    assign o_clearing        = (r_state == ST_CLEAR);
    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = OUT_POS_W'(r_out_lin);
    assign o_scrolled        = r_out_scr;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_row       = r_row;
        n_prow      = r_prow;
        n_top       = r_top;
        n_col       = r_col;
        n_wcol      = r_wcol;
        n_lin       = r_lin;
        n_past      = r_past;
        n_cmd       = r_cmd;
        n_scr       = r_scr;
        n_out_valid = r_out_valid;
        n_out_lin   = r_out_lin;
        n_out_scr   = r_out_scr;
        w_we        = 1'b0;
        w_data      = w_blank;
        w_wrow      = r_prow;
        w_wc        = r_wcol;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                w_we   = 1'b1;
                w_data = RESET_CELL;
                if (r_clr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_q_valid && w_out_free) begin
                    n_cmd  = i_q_item;
                    n_wcol = '0;
                    if (r_past) begin
                        // scroll: old top row becomes the new bottom row
                        n_state = ST_SCROLL;
                        n_scr   = 1'b1;
                        n_row   = LAST_ROW;
                        n_col   = '0;
                        n_lin   = BOTTOM_LIN;
                        n_past  = 1'b0;
                        n_prow  = r_top;
                        n_top   = (r_top == LAST_ROW) ? '0 : r_top + ROW_W'(1);
                    end else begin
                        n_state = ST_EXEC;
                        n_scr   = 1'b0;
                    end
                end
            end
            ST_SCROLL: begin
                w_we = 1'b1;
                if (r_wcol == LAST_COL) begin
                    n_state = ST_EXEC;
                end else begin
                    n_wcol = r_wcol + COL_W'(1);
                end
            end
            ST_EXEC: begin
                case (r_cmd.kind)
                    CMD_CR: begin
                        n_col       = '0;
                        n_lin       = r_lin - LIN_W'(r_col);
                        n_out_valid = 1'b1;
                        n_out_lin   = n_lin;
                        n_out_scr   = r_scr;
                        n_state     = ST_IDLE;
                    end
                    CMD_LF: begin
                        n_wcol  = r_col;
                        n_state = ST_LF;
                    end
                    default: begin
                        w_we   = 1'b1;
                        w_wc   = r_col;
                        w_data = {i_attr.text, r_cmd.code};
                        n_lin  = r_lin + LIN_W'(1);
                        if (r_col == LAST_COL) begin
                            n_col = '0;
                            if (r_row == LAST_ROW) begin
                                n_past = 1'b1;
                            end else begin
                                n_row  = r_row + ROW_W'(1);
                                n_prow = (r_prow == LAST_ROW) ? '0 : r_prow + ROW_W'(1);
                            end
                        end else begin
                            n_col = r_col + COL_W'(1);
                        end
                        n_out_valid = 1'b1;
                        n_out_lin   = n_lin;
                        n_out_scr   = r_scr;
                        n_state     = ST_IDLE;
                    end
                endcase
            end
            ST_LF: begin
                w_we = 1'b1;
                if (r_wcol == LAST_COL) begin
                    n_col = '0;
                    n_lin = r_lin - LIN_W'(r_col) + LIN_W'(COLUMNS);
                    if (r_row == LAST_ROW) begin
                        n_past = 1'b1;
                    end else begin
                        n_row  = r_row + ROW_W'(1);
                        n_prow = (r_prow == LAST_ROW) ? '0 : r_prow + ROW_W'(1);
                    end
                    n_out_valid = 1'b1;
                    n_out_lin   = n_lin;
                    n_out_scr   = r_scr;
                    n_state     = ST_IDLE;
                end else begin
                    n_wcol = r_wcol + COL_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_row       <= '0;
            r_prow      <= '0;
            r_top       <= '0;
            r_col       <= '0;
            r_lin       <= '0;
            r_past      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_row       <= n_row;
            r_prow      <= n_prow;
            r_top       <= n_top;
            r_col       <= n_col;
            r_lin       <= n_lin;
            r_past      <= n_past;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wcol    <= n_wcol;
        r_cmd     <= n_cmd;
        r_scr     <= n_scr;
        r_out_lin <= n_out_lin;
        r_out_scr <= n_out_scr;
    end

    // screen store, single write port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_addr] <= w_data;
        end
    end

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_out_valid)
        else $error("result produced during clearing pass");

    a_past_lin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_past |-> (r_lin == LIN_W'(CELL_COUNT) && r_row == LAST_ROW))
        else $error("past-end cursor inconsistent");

    a_lin_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_past |-> (r_lin == LIN_W'(r_row * COLUMNS) + LIN_W'(r_col)))
        else $error("linear cursor out of step with row and column");

    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_scr) |-> (r_out_lin >= BOTTOM_LIN))
        else $error("scroll reported with cursor above bottom row");

endmodule
`default_nettype wire

FILE: src/text_mode_terminal_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// Character-at-a-time writer into a COLUMNS x ROWS text-mode screen store.
// ----------------------------------------------------------------------------
// After reset the block sweeps the screen store to blank cells (attribute 7,
// space), one cell a cycle; no byte transfer is taken until that pass ends,
// but register writes are. Each byte transfer yields exactly one result
// transfer carrying the new cursor position and a scroll flag. Bytes enter
// a two-entry queue and a back-end sequencer executes them against the
// store's single write port: a line feed blanks the rest of the row one
// cell a cycle, and a pending scroll first blanks the new bottom row.
// Scrolling moves a ring pointer over the rows, so no cell is copied. A
// waiting result holds the sequencer idle; the next command is taken in
// the cycle that result is transferred.
// Registers: index 0 text attribute, index 1 blank attribute; write them
// only while the block is idle.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer #(
    parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration write channel
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [tmtw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [tmtw_pkg::ATTR_W-1:0]     i_cfg_data,
    // byte input
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [tmtw_pkg::CHAR_W-1:0]     i_char_code,
    // result output
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [tmtw_pkg::OUT_POS_W-1:0]  o_cursor_position,
    output logic                            o_scrolled
);
    import tmtw_pkg::*;

    t_attr r_attr;
    logic  w_clearing;
    logic  w_front_ready;
    logic  w_q_valid;
    logic  w_q_ready;
    t_item w_q_item;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr.text  <= RESET_ATTR;
            r_attr.blank <= RESET_ATTR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TEXT_ATTR:  r_attr.text  <= i_cfg_data;
                REG_BLANK_ATTR: r_attr.blank <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // hold off byte transfers until the clearing pass is done
    assign o_in_ready = w_front_ready && !w_clearing;

    tmtw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid && !w_clearing),
        .o_ready   (w_front_ready),
        .i_code    (i_char_code),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_item  (w_q_item)
    );

    tmtw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .o_q_ready         (w_q_ready),
        .i_q_item          (w_q_item),
        .i_attr            (r_attr),
        .o_clearing        (w_clearing),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_cursor_position (o_cursor_position),
        .o_scrolled        (o_scrolled)
    );

endmodule
`default_nettype wire
